// ----- hdl/lef_pkg.sv -----
// Package for the LED envelope fader: constants, codes, payload and control types.
package lef_pkg;

    localparam int TIME_BITS       = 16;
    localparam int ELAPSED_BITS    = 20;
    localparam int LEVEL_FRAC_BITS = 15;
    localparam int LEVEL_BITS      = 16;
    localparam int COLOR_BITS      = 8;
    localparam int CFG_DATA_BITS   = 64;
    localparam int CFG_INDEX_BITS  = 3;
    localparam int PROD_BITS       = LEVEL_BITS + TIME_BITS;
    localparam int DIV_CNT_BITS    = $clog2(PROD_BITS);
    localparam int BLEND_BITS      = COLOR_BITS + LEVEL_BITS + 1;

    localparam logic [LEVEL_BITS-1:0] LEVEL_FULL = LEVEL_BITS'(1 << LEVEL_FRAC_BITS);

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_PRE_DELAY    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ATTACK_TIME  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DECAY_TIME   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SUSTAIN_TIME = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RELEASE_TIME = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LEVEL_SET    = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_REPEAT_MODE  = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COLOUR_PAIR  = 3'd7;

    // action codes
    localparam logic [1:0] ACT_TICK       = 2'd0;
    localparam logic [1:0] ACT_START      = 2'd1;
    localparam logic [1:0] ACT_START_HELD = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_DELAY,
        PH_ATTACK,
        PH_DECAY,
        PH_SUSTAIN,
        PH_RELEASE,
        PH_FINISHED
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV,
        ST_BLEND,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]           action;
        logic [TIME_BITS-1:0] tick_ms;
    } item_t;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] level;
        logic [COLOR_BITS-1:0] red;
        logic [COLOR_BITS-1:0] green;
        logic [COLOR_BITS-1:0] blue;
        logic [2:0]            phase;
        logic                  restarted;
    } result_t;

    // color index 0 blue, 1 green, 2 red
    typedef struct packed {
        logic [TIME_BITS-1:0]             pre_delay;
        logic [TIME_BITS-1:0]             attack_time;
        logic [TIME_BITS-1:0]             decay_time;
        logic [TIME_BITS-1:0]             sustain_time;
        logic [TIME_BITS-1:0]             release_time;
        logic [LEVEL_BITS-1:0]            lvl_initial;
        logic [LEVEL_BITS-1:0]            lvl_attack;
        logic [LEVEL_BITS-1:0]            lvl_sustain;
        logic [LEVEL_BITS-1:0]            lvl_end;
        logic                             repeat_mode;
        logic [2:0][COLOR_BITS-1:0]       fg;
        logic [2:0][COLOR_BITS-1:0]       bg;
    } cfg_t;

    typedef struct packed {
        logic                  start;
        logic [PROD_BITS-1:0]  dividend;
        logic [TIME_BITS-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [PROD_BITS-1:0]  quotient;
    } div_res_t;

    function automatic logic [LEVEL_BITS-1:0] clamp_level(input logic [LEVEL_BITS-1:0] v);
        clamp_level = (v > LEVEL_FULL) ? LEVEL_FULL : v;
    endfunction

endpackage

// ----- hdl/lef_cfg.sv -----
// Configuration register file with level clamping and color unpacking.
module lef_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [lef_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [lef_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output lef_pkg::cfg_t                      cfg
);
    import lef_pkg::*;

    logic [TIME_BITS-1:0]       pre_delay_reg, attack_time_reg, decay_time_reg;
    logic [TIME_BITS-1:0]       sustain_time_reg, release_time_reg;
    logic [4*LEVEL_BITS-1:0]    level_set_reg;
    logic                       repeat_mode_reg;
    logic [6*COLOR_BITS-1:0]    colour_pair_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_delay_reg    <= '0;
            attack_time_reg  <= '0;
            decay_time_reg   <= '0;
            sustain_time_reg <= '0;
            release_time_reg <= '0;
            level_set_reg    <= '0;
            repeat_mode_reg  <= 1'b0;
            colour_pair_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PRE_DELAY:    pre_delay_reg    <= cfg_data[TIME_BITS-1:0];
                REG_ATTACK_TIME:  attack_time_reg  <= cfg_data[TIME_BITS-1:0];
                REG_DECAY_TIME:   decay_time_reg   <= cfg_data[TIME_BITS-1:0];
                REG_SUSTAIN_TIME: sustain_time_reg <= cfg_data[TIME_BITS-1:0];
                REG_RELEASE_TIME: release_time_reg <= cfg_data[TIME_BITS-1:0];
                REG_LEVEL_SET:    level_set_reg    <= cfg_data[4*LEVEL_BITS-1:0];
                REG_REPEAT_MODE:  repeat_mode_reg  <= cfg_data[0];
                REG_COLOUR_PAIR:  colour_pair_reg  <= cfg_data[6*COLOR_BITS-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        cfg.pre_delay    = pre_delay_reg;
        cfg.attack_time  = attack_time_reg;
        cfg.decay_time   = decay_time_reg;
        cfg.sustain_time = sustain_time_reg;
        cfg.release_time = release_time_reg;
        cfg.lvl_initial  = clamp_level(level_set_reg[0*LEVEL_BITS +: LEVEL_BITS]);
        cfg.lvl_attack   = clamp_level(level_set_reg[1*LEVEL_BITS +: LEVEL_BITS]);
        cfg.lvl_sustain  = clamp_level(level_set_reg[2*LEVEL_BITS +: LEVEL_BITS]);
        cfg.lvl_end      = clamp_level(level_set_reg[3*LEVEL_BITS +: LEVEL_BITS]);
        cfg.repeat_mode  = repeat_mode_reg;
        cfg.fg           = colour_pair_reg[3*COLOR_BITS-1:0];
        cfg.bg           = colour_pair_reg[6*COLOR_BITS-1:3*COLOR_BITS];
    end

endmodule

// ----- hdl/lef_divider.sv -----
// Restoring divider, one quotient bit per cycle.
module lef_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  lef_pkg::div_req_t req,
    output lef_pkg::div_res_t res
);
    import lef_pkg::*;

    localparam logic [DIV_CNT_BITS-1:0] LAST_STEP = DIV_CNT_BITS'(PROD_BITS - 1);

    logic [TIME_BITS-1:0]    rem_reg, rem_next;
    logic [PROD_BITS-1:0]    quo_reg, quo_next;
    logic [TIME_BITS-1:0]    divisor_reg, divisor_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [TIME_BITS:0]      trial;
    logic [TIME_BITS:0]      trial_diff;
    logic                    fits;

    always_comb
    begin
        trial        = {rem_reg, quo_reg[PROD_BITS-1]};
        trial_diff   = trial - {1'b0, divisor_reg};
        fits         = trial >= {1'b0, divisor_reg};
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;
        cnt_next     = cnt_reg;
        busy_next    = busy_reg;
        done_next    = 1'b0;
        if (req.start)
        begin
            rem_next     = '0;
            quo_next     = req.dividend;
            divisor_next = req.divisor;
            cnt_next     = '0;
            busy_next    = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial_diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
            quo_next = {quo_reg[PROD_BITS-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
    end

    assign res.done     = done_reg;
    assign res.quotient = quo_reg;

endmodule

// ----- hdl/led_envelope_fader.sv -----
// Top level of the LED envelope fader: sequencer, envelope state and color blend.
//
// Usage:
//   item channel (item_valid / item_stall / item): one transfer per action,
//     a tick carrying elapsed milliseconds, a start, or a start from the
//     currently held level. item_stall is high while an item is in work.
//   result channel (result_valid / result_stall / result): exactly one
//     transfer per item with the held level, blended RGB, phase and the
//     repeat-restart flag.
//   cfg port (cfg_we / cfg_index / cfg_data): single-cycle register writes, to be
//     issued by the user only while the block is idle; the block does not enforce it.
// Processing: an item that needs no ramp goes through up to five phase-walk
//   steps, three blend steps and one load of the output register. An item
//   inside a ramp also passes a multiply step, a divider start step and the
//   32-step serial divider that scales the ramp product.
//   One item is in work at a time.
// Reset clears all configuration, the envelope (not running, level 0) and
//   empties the output register.
// A stalled result is held in the output register; the next item is taken
//   meanwhile and waits before its result load until the register drains.
module led_envelope_fader (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_stall,
    input  lef_pkg::item_t                     item,
    output logic                               result_valid,
    input  logic                               result_stall,
    output lef_pkg::result_t                   result,
    input  logic                               cfg_we,
    input  logic [lef_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [lef_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import lef_pkg::*;

    localparam logic [ELAPSED_BITS-1:0] ELAPSED_MAX = '1;

    cfg_t     cfg;
    div_req_t div_req;
    div_res_t div_res;

    // control state
    state_t  state_reg, state_next;
    logic    running_reg, running_next;
    logic    result_valid_reg, result_valid_next;
    logic [1:0] ch_reg, ch_next;

    // envelope state
    logic [ELAPSED_BITS-1:0] elapsed_reg, elapsed_next;
    logic [LEVEL_BITS-1:0]   held_reg, held_next;
    logic [LEVEL_BITS-1:0]   start_lvl_reg, start_lvl_next;

    // per-item working registers
    logic [ELAPSED_BITS-1:0] walk_e_reg, walk_e_next;
    phase_t                  phase_reg, phase_next;
    logic                    restarted_reg, restarted_next;
    logic [LEVEL_BITS-1:0]   from_reg, from_next;
    logic [LEVEL_BITS-1:0]   diff_reg, diff_next;
    logic                    up_reg, up_next;
    logic [TIME_BITS-1:0]    tval_reg, tval_next;
    logic [TIME_BITS-1:0]    span_reg, span_next;
    logic [PROD_BITS-1:0]    prod_reg, prod_next;
    logic [2:0][COLOR_BITS-1:0] rgb_reg, rgb_next;
    result_t                 result_reg, result_next;

    // combinational helpers
    logic                    item_take;
    logic                    result_take;
    logic [ELAPSED_BITS:0]   tick_sum;
    logic [TIME_BITS-1:0]    dur;
    logic                    in_phase;
    logic [LEVEL_BITS-1:0]   ramp_from, ramp_to;
    logic [LEVEL_BITS-1:0]   quo_lvl;
    logic [LEVEL_BITS-1:0]   inv_amt;
    logic [BLEND_BITS-1:0]   mix;

    lef_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lef_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .res   (div_res)
    );

    assign item_stall   = (state_reg != ST_IDLE);
    assign item_take    = item_valid && !item_stall;
    assign result_take  = result_valid_reg && !result_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // duration and ramp endpoints of the phase under test
    always_comb
    begin
        dur       = '0;
        ramp_from = start_lvl_reg;
        ramp_to   = cfg.lvl_attack;
        unique case (phase_reg)
            PH_DELAY:
            begin
                dur = cfg.pre_delay;
            end
            PH_ATTACK:
            begin
                dur       = cfg.attack_time;
                ramp_from = start_lvl_reg;
                ramp_to   = cfg.lvl_attack;
            end
            PH_DECAY:
            begin
                dur       = cfg.decay_time;
                ramp_from = cfg.lvl_attack;
                ramp_to   = cfg.lvl_sustain;
            end
            PH_SUSTAIN:
            begin
                dur = cfg.sustain_time;
            end
            PH_RELEASE:
            begin
                dur       = cfg.release_time;
                ramp_from = cfg.lvl_sustain;
                ramp_to   = cfg.lvl_end;
            end
            default:
            begin
                dur = '0;
            end
        endcase
    end

    always_comb
    begin
        tick_sum = {1'b0, elapsed_reg} + (ELAPSED_BITS + 1)'(item.tick_ms);
        in_phase = walk_e_reg < ELAPSED_BITS'(dur);
        quo_lvl  = div_res.quotient[LEVEL_BITS-1:0];
        inv_amt  = LEVEL_FULL - held_reg;
        mix      = BLEND_BITS'(cfg.fg[ch_reg]) * BLEND_BITS'(held_reg)
                 + BLEND_BITS'(cfg.bg[ch_reg]) * BLEND_BITS'(inv_amt);
    end

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        running_next      = running_reg;
        result_valid_next = result_valid_reg && !result_take;
        ch_next           = ch_reg;
        elapsed_next      = elapsed_reg;
        held_next         = held_reg;
        start_lvl_next    = start_lvl_reg;
        walk_e_next       = walk_e_reg;
        phase_next        = phase_reg;
        restarted_next    = restarted_reg;
        from_next         = from_reg;
        diff_next         = diff_reg;
        up_next           = up_reg;
        tval_next         = tval_reg;
        span_next         = span_reg;
        prod_next         = prod_reg;
        rgb_next          = rgb_reg;
        result_next       = result_reg;
        div_req.start     = 1'b0;
        div_req.dividend  = prod_reg;
        div_req.divisor   = span_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_take)
                begin
                    restarted_next = 1'b0;
                    ch_next        = '0;
                    if (item.action == ACT_START || item.action == ACT_START_HELD)
                    begin
                        start_lvl_next = (item.action == ACT_START) ? cfg.lvl_initial
                                                                    : held_reg;
                        running_next   = 1'b1;
                        elapsed_next   = '0;
                        walk_e_next    = '0;
                        phase_next     = PH_DELAY;
                        state_next     = ST_WALK;
                    end
                    else if (running_reg)
                    begin
                        if (item.action == ACT_TICK)
                        begin
                            elapsed_next = tick_sum[ELAPSED_BITS] ? ELAPSED_MAX
                                                                  : tick_sum[ELAPSED_BITS-1:0];
                        end
                        walk_e_next = (item.action == ACT_TICK && !tick_sum[ELAPSED_BITS])
                                    ? tick_sum[ELAPSED_BITS-1:0]
                                    : ((item.action == ACT_TICK) ? ELAPSED_MAX : elapsed_reg);
                        phase_next  = PH_DELAY;
                        state_next  = ST_WALK;
                    end
                    else
                    begin
                        // not started: level stays, just re-blend
                        phase_next = PH_IDLE;
                        state_next = ST_BLEND;
                    end
                end
            end

            ST_WALK:
            begin
                // one phase per cycle: compare against its length or skip past it
                if (in_phase)
                begin
                    unique case (phase_reg)
                        PH_DELAY:
                        begin
                            held_next  = start_lvl_reg;
                            state_next = ST_BLEND;
                        end
                        PH_SUSTAIN:
                        begin
                            held_next  = cfg.lvl_sustain;
                            state_next = ST_BLEND;
                        end
                        default:
                        begin
                            from_next  = ramp_from;
                            up_next    = ramp_to >= ramp_from;
                            diff_next  = (ramp_to >= ramp_from) ? ramp_to - ramp_from
                                                                 : ramp_from - ramp_to;
                            tval_next  = walk_e_reg[TIME_BITS-1:0];
                            span_next  = dur;
                            state_next = ST_MUL;
                        end
                    endcase
                end
                else
                begin
                    walk_e_next = walk_e_reg - ELAPSED_BITS'(dur);
                    if (phase_reg == PH_RELEASE)
                    begin
                        phase_next = PH_FINISHED;
                        held_next  = cfg.lvl_end;
                        if (cfg.repeat_mode)
                        begin
                            elapsed_next   = '0;
                            restarted_next = 1'b1;
                        end
                        state_next = ST_BLEND;
                    end
                    else
                    begin
                        phase_next = phase_t'(phase_reg + 3'd1);
                    end
                end
            end

            ST_MUL:
            begin
                prod_next  = PROD_BITS'(diff_reg) * PROD_BITS'(tval_reg);
                state_next = ST_DIV_GO;
            end

            ST_DIV_GO:
            begin
                div_req.start = 1'b1;
                state_next    = ST_DIV;
            end

            ST_DIV:
            begin
                if (div_res.done)
                begin
                    held_next  = up_reg ? from_reg + quo_lvl : from_reg - quo_lvl;
                    state_next = ST_BLEND;
                end
            end

            ST_BLEND:
            begin
                // one color component per cycle: blue, green, red
                rgb_next[ch_reg] = mix[LEVEL_FRAC_BITS +: COLOR_BITS];
                if (ch_reg == 2'd2)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    ch_next = ch_reg + 2'd1;
                end
            end

            ST_DONE:
            begin
                if (!result_valid_reg || result_take)
                begin
                    result_next.level     = held_reg;
                    result_next.red       = rgb_reg[2];
                    result_next.green     = rgb_reg[1];
                    result_next.blue      = rgb_reg[0];
                    result_next.phase     = phase_reg;
                    result_next.restarted = restarted_reg;
                    result_valid_next     = 1'b1;
                    state_next            = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            running_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
            ch_reg           <= '0;
            elapsed_reg      <= '0;
            held_reg         <= '0;
            start_lvl_reg    <= '0;
            phase_reg        <= PH_IDLE;
            restarted_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            running_reg      <= running_next;
            result_valid_reg <= result_valid_next;
            ch_reg           <= ch_next;
            elapsed_reg      <= elapsed_next;
            held_reg         <= held_next;
            start_lvl_reg    <= start_lvl_next;
            phase_reg        <= phase_next;
            restarted_reg    <= restarted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        walk_e_reg <= walk_e_next;
        from_reg   <= from_next;
        diff_reg   <= diff_next;
        up_reg     <= up_next;
        tval_reg   <= tval_next;
        span_reg   <= span_next;
        prod_reg   <= prod_next;
        rgb_reg    <= rgb_next;
        result_reg <= result_next;
    end

endmodule
